// ===== design/srpt_pkg.sv =====
// Shared constants and types for the run-length step position probe.
package srpt_pkg;

  localparam int unsigned NUM_AXES        = 4;
  localparam int unsigned COUNT_BITS_DEF  = 16;
  localparam int unsigned MASK_W          = NUM_AXES;
  localparam int unsigned TICK_W          = 32;
  localparam int unsigned TARGET_W        = 31;
  localparam int unsigned POS_W           = 32;
  localparam int unsigned STATUS_W        = 2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_EXACT_END = 2'd1,
    STATUS_PAST_END  = 2'd2
  } status_t;

  typedef logic [POS_W-1:0] pos_t;

endpackage

// ===== design/srpt_cmd_if.sv =====
// Valid/ready channel carrying one run-length step command.
interface srpt_cmd_if #(
  parameter int unsigned COUNT_BITS = srpt_pkg::COUNT_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [COUNT_BITS-1:0]       run_count;
  logic [srpt_pkg::MASK_W-1:0] step_mask;
  logic [srpt_pkg::MASK_W-1:0] dir_mask;
  logic                        is_last;

  modport source (output valid, run_count, step_mask, dir_mask, is_last, input ready);
  modport sink   (input valid, run_count, step_mask, dir_mask, is_last, output ready);
endinterface

// ===== design/srpt_res_if.sv =====
// Valid/ready channel carrying the axis positions and status of one probe result.
interface srpt_res_if;
  logic                          valid;
  logic                          ready;
  logic signed [srpt_pkg::POS_W-1:0] axis0_pos;
  logic signed [srpt_pkg::POS_W-1:0] axis1_pos;
  logic signed [srpt_pkg::POS_W-1:0] axis2_pos;
  logic signed [srpt_pkg::POS_W-1:0] axis3_pos;
  logic [srpt_pkg::STATUS_W-1:0] status;

  modport source (output valid, axis0_pos, axis1_pos, axis2_pos, axis3_pos, status,
                  input ready);
  modport sink   (input valid, axis0_pos, axis1_pos, axis2_pos, axis3_pos, status,
                  output ready);
endinterface

// ===== design/step_run_position_at_tick_unit.sv =====
// Top level of the run-length step position probe.
//
// Usage: commands arrive on cmd (valid/ready), one per transfer. Each one
// repeats a step/direction pattern for run_count ticks; a list of commands
// ends with is_last. The unit tracks the tick index and four 32-bit axis
// positions and emits at most one result per command on res: the positions
// at target_tick with status found, or at the end of a list exact_end (the
// target is the list length) or past the end (positions zero).
// The user writes target_tick via cfg_we/cfg_wdata only while idle; not enforced.
//
// Timing: a command is registered at its transfer into the input stage and
// evaluated from there once the result register is free or being taken,
// which updates the tick/position state and loads the result register that
// drives res.valid. One command is taken every cycle while res does not
// stall; the state loop is one add per axis plus one tick add and compare.
//
// Reset clears the list state, the target and both stages. When res stalls
// with a result pending, the input stage holds one command and cmd.ready
// drops until the result is taken.
module step_run_position_at_tick_unit
  import srpt_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [TARGET_W-1:0] cfg_wdata,
  srpt_cmd_if.sink            cmd,
  srpt_res_if.source          res
);

  // configuration and list state
  logic [TARGET_W-1:0] target_tick;
  logic [TICK_W-1:0]   tick_base;
  pos_t                axis_accum [NUM_AXES];
  logic                answered;

  // input stage
  logic                  s1_valid;
  logic [COUNT_BITS-1:0] s1_count;
  logic [MASK_W-1:0]     s1_step;
  logic [MASK_W-1:0]     s1_dir;
  logic                  s1_last;
  logic                  s1_go;

  // result register
  logic    res_valid;
  pos_t    res_pos [NUM_AXES];
  status_t res_status;

  // evaluation
  logic [TICK_W-1:0] target_ext;
  logic [TICK_W-1:0] count_ext;
  logic [TICK_W-1:0] diff;
  logic [TICK_W-1:0] span;
  logic [TICK_W:0]   base_sum;
  logic [TICK_W-1:0] tick_base_next;
  logic              in_window;
  logic              emit;
  status_t           status_next;
  pos_t              pos_sum [NUM_AXES];

  assign s1_go     = s1_valid && (!res_valid || res.ready);
  assign cmd.ready = !s1_valid || s1_go;

  assign target_ext = {1'b0, target_tick};
  assign count_ext  = {{(TICK_W-COUNT_BITS){1'b0}}, s1_count};
  assign diff       = target_ext - tick_base;
  assign in_window  = !answered && (target_ext >= tick_base) && (diff < count_ext);
  assign span       = in_window ? diff : count_ext;
  assign base_sum   = {1'b0, tick_base} + {1'b0, count_ext};

  always_comb begin
    for (int j = 0; j < NUM_AXES; j++) begin
      if (!s1_step[j]) begin
        pos_sum[j] = axis_accum[j];
      end else if (s1_dir[j]) begin
        pos_sum[j] = axis_accum[j] + span;
      end else begin
        pos_sum[j] = axis_accum[j] - span;
      end
    end
  end

  always_comb begin
    if (answered || in_window) begin
      tick_base_next = tick_base;
    end else if (base_sum[TICK_W]) begin
      tick_base_next = '1;   // saturate so a long list never matches again
    end else begin
      tick_base_next = base_sum[TICK_W-1:0];
    end
  end

  assign emit = in_window || (s1_last && !answered);

  always_comb begin
    if (in_window) begin
      status_next = STATUS_FOUND;
    end else if (tick_base_next == target_ext) begin
      status_next = STATUS_EXACT_END;
    end else begin
      status_next = STATUS_PAST_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_tick <= '0;
    end else if (cfg_we) begin
      target_tick <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_count <= cmd.run_count;
      s1_step  <= cmd.step_mask;
      s1_dir   <= cmd.dir_mask;
      s1_last  <= cmd.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_base <= '0;
      answered  <= 1'b0;
      for (int j = 0; j < NUM_AXES; j++) begin
        axis_accum[j] <= '0;
      end
    end else if (s1_go) begin
      if (s1_last) begin
        // end of list: start the next one from zero
        tick_base <= '0;
        answered  <= 1'b0;
        for (int j = 0; j < NUM_AXES; j++) begin
          axis_accum[j] <= '0;
        end
      end else begin
        tick_base <= tick_base_next;
        if (in_window) begin
          answered <= 1'b1;
        end
        if (!answered && !in_window) begin
          for (int j = 0; j < NUM_AXES; j++) begin
            axis_accum[j] <= pos_sum[j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go) begin
      res_valid <= emit;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      res_status <= status_next;
      for (int j = 0; j < NUM_AXES; j++) begin
        res_pos[j] <= (status_next == STATUS_PAST_END) ? '0 : pos_sum[j];
      end
    end
  end

  assign res.valid     = res_valid;
  assign res.status    = res_status;
  assign res.axis0_pos = res_pos[0];
  assign res.axis1_pos = res_pos[1];
  assign res.axis2_pos = res_pos[2];
  assign res.axis3_pos = res_pos[3];

endmodule

// ===== design/srpt_checker.sv =====
// Port-level checks for the run-length step position probe, bound to the top level.
module srpt_checker
  import srpt_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input logic [POS_W-1:0]    axis0_pos,
  input logic [POS_W-1:0]    axis1_pos,
  input logic [POS_W-1:0]    axis2_pos,
  input logic [POS_W-1:0]    axis3_pos,
  input logic [STATUS_W-1:0] status
);

  // no result may be pending right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("stalled result dropped");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (status == STATUS_FOUND || status == STATUS_EXACT_END ||
                   status == STATUS_PAST_END))
    else $error("undefined status code");

  a_past_end_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == STATUS_PAST_END) |->
      (axis0_pos == '0 && axis1_pos == '0 && axis2_pos == '0 && axis3_pos == '0))
    else $error("past-end result carries nonzero positions");

endmodule

bind step_run_position_at_tick_unit srpt_checker u_srpt_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .axis0_pos (res.axis0_pos),
  .axis1_pos (res.axis1_pos),
  .axis2_pos (res.axis2_pos),
  .axis3_pos (res.axis3_pos),
  .status    (res.status)
);
